>>> design/knot_pkg.sv
// ============================================================================
// knot_pkg
// Shared types, lengths and round-constant tables for the KNOT-256
// permutation block.
// ============================================================================
package knot_pkg;

    // Row and count widths
    localparam int ROW_W = 64;
    localparam int CNT_W = 7;
    localparam int RC_W  = 7;

    // Round-constant sequence lengths
    localparam logic [CNT_W-1:0] LEN_SEQ6 = 7'd52;
    localparam logic [CNT_W-1:0] LEN_SEQ7 = 7'd104;

    // Constant set codes
    localparam logic SET_SEQ6 = 1'b0;
    localparam logic SET_SEQ7 = 1'b1;

    // Input item
    typedef struct packed {
        logic [ROW_W-1:0] row_0_in;
        logic [ROW_W-1:0] row_1_in;
        logic [ROW_W-1:0] row_2_in;
        logic [ROW_W-1:0] row_3_in;
        logic [CNT_W-1:0] round_count;
    } t_in;

    // Result item
    typedef struct packed {
        logic [ROW_W-1:0] row_0_out;
        logic [ROW_W-1:0] row_1_out;
        logic [ROW_W-1:0] row_2_out;
        logic [ROW_W-1:0] row_3_out;
        logic             count_clipped;
    } t_out;

    // Working state, index 0 is row 0
    typedef logic [3:0][ROW_W-1:0] t_rows;

    // 6-bit sequence, 52 entries
    localparam logic [5:0] SEQ6 [52] = '{
        6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h21, 6'h03, 6'h06, 6'h0c, 6'h18, 6'h31, 6'h22,
        6'h05, 6'h0a, 6'h14, 6'h29, 6'h13, 6'h27, 6'h0f, 6'h1e, 6'h3d, 6'h3a, 6'h34, 6'h28,
        6'h11, 6'h23, 6'h07, 6'h0e, 6'h1c, 6'h39, 6'h32, 6'h24, 6'h09, 6'h12, 6'h25, 6'h0b,
        6'h16, 6'h2d, 6'h1b, 6'h37, 6'h2e, 6'h1d, 6'h3b, 6'h36, 6'h2c, 6'h19, 6'h33, 6'h26,
        6'h0d, 6'h1a, 6'h35, 6'h2a
    };

    // 7-bit sequence, 104 entries
    localparam logic [6:0] SEQ7 [104] = '{
        7'h01, 7'h02, 7'h04, 7'h08, 7'h10, 7'h20, 7'h41, 7'h03, 7'h06, 7'h0c, 7'h18, 7'h30,
        7'h61, 7'h42, 7'h05, 7'h0a, 7'h14, 7'h28, 7'h51, 7'h23, 7'h47, 7'h0f, 7'h1e, 7'h3c,
        7'h79, 7'h72, 7'h64, 7'h48, 7'h11, 7'h22, 7'h45, 7'h0b, 7'h16, 7'h2c, 7'h59, 7'h33,
        7'h67, 7'h4e, 7'h1d, 7'h3a, 7'h75, 7'h6a, 7'h54, 7'h29, 7'h53, 7'h27, 7'h4f, 7'h1f,
        7'h3e, 7'h7d, 7'h7a, 7'h74, 7'h68, 7'h50, 7'h21, 7'h43, 7'h07, 7'h0e, 7'h1c, 7'h38,
        7'h71, 7'h62, 7'h44, 7'h09, 7'h12, 7'h24, 7'h49, 7'h13, 7'h26, 7'h4d, 7'h1b, 7'h36,
        7'h6d, 7'h5a, 7'h35, 7'h6b, 7'h56, 7'h2d, 7'h5b, 7'h37, 7'h6f, 7'h5e, 7'h3d, 7'h7b,
        7'h76, 7'h6c, 7'h58, 7'h31, 7'h63, 7'h46, 7'h0d, 7'h1a, 7'h34, 7'h69, 7'h52, 7'h25,
        7'h4b, 7'h17, 7'h2e, 7'h5d, 7'h3b, 7'h77, 7'h6e, 7'h5c
    };

    // Round constant for round idx of the chosen set
    function automatic logic [RC_W-1:0] round_const(input logic set,
                                                    input logic [CNT_W-1:0] idx);
        logic [RC_W-1:0] rc;
        rc = '0;
        if (set == SET_SEQ7) begin
            if (idx < LEN_SEQ7) rc = SEQ7[idx];
        end else begin
            if (idx < LEN_SEQ6) rc = {1'b0, SEQ6[idx[5:0]]};
        end
        return rc;
    endfunction

endpackage

>>> design/knot_round.sv
// ============================================================================
// knot_round
// One KNOT-256 round: constant add into row 0, bit-sliced 4-bit S-box
// over all 64 columns, then row rotations by 1, 8 and 25.
// ============================================================================
module knot_round (
    input  knot_pkg::t_rows                i_rows,
    input  logic [knot_pkg::RC_W-1:0]      i_rc,
    output knot_pkg::t_rows                o_rows
);

    logic [knot_pkg::ROW_W-1:0] a0, a1, a2, a3;
    logic [knot_pkg::ROW_W-1:0] na, a3x, mix, nb;
    logic [knot_pkg::ROW_W-1:0] s0, s1, s2, s3;

    // Constant add
    assign a0 = i_rows[0] ^ {{(knot_pkg::ROW_W-knot_pkg::RC_W){1'b0}}, i_rc};
    assign a1 = i_rows[1];
    assign a2 = i_rows[2];
    assign a3 = i_rows[3];

    // Bit-sliced S-box
    assign na  = ~a0;
    assign a3x = a2 ^ (a1 & na);
    assign s3  = a3 ^ a3x;
    assign mix = a3 ^ na;
    assign s2  = (a1 | a2) ^ mix;
    assign nb  = a1 ^ a3;
    assign s0  = nb ^ (a3x & mix);
    assign s1  = a3x ^ (s2 & nb);

    // Row rotations
    assign o_rows[0] = s0;
    assign o_rows[1] = {s1[knot_pkg::ROW_W-2:0], s1[knot_pkg::ROW_W-1]};
    assign o_rows[2] = {s2[knot_pkg::ROW_W-9:0], s2[knot_pkg::ROW_W-1 -: 8]};
    assign o_rows[3] = {s3[knot_pkg::ROW_W-26:0], s3[knot_pkg::ROW_W-1 -: 25]};

endmodule

>>> design/knot256_permutation.sv
// ============================================================================
// knot256_permutation
// KNOT-256 permutation with one shared round unit stepped by a round
// counter; one round per clock.
// ============================================================================
//
//  channel   | signals                              | transfer when
//  ----------+--------------------------------------+------------------------
//  command   | start, busy, i_item                  | start & !busy
//  result    | o_result_valid, o_result             | o_result_valid (no stall)
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data | i_cfg_valid & o_cfg_ready
//
//  An item with n rounds (after saturation to 52 or 104) holds busy for one
//  pass through the round unit per round; the result strobe is registered
//  and shown in the cycle after the last round (n = 0 skips the rounds).
//  A new command may be taken in the cycle the result is shown.
//  Config is ready only while idle and start is low, so a command always
//  runs under the set that was in place when it was taken.
//  Synchronous active-low reset clears the sequencer and selects the 6-bit
//  constant set. The result side cannot stall.
//
module knot256_permutation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  knot_pkg::t_in    i_item,
    output logic             o_result_valid,
    output knot_pkg::t_out   o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          r_state, n_state;
    logic                          r_valid, n_valid;
    logic                          r_set,   n_set;
    logic                          r_clip,  n_clip;
    logic [knot_pkg::CNT_W-1:0]    r_rnd,   n_rnd;
    logic [knot_pkg::CNT_W-1:0]    r_last,  n_last;
    knot_pkg::t_rows               r_rows,  n_rows;

    knot_pkg::t_rows               rnd_out;
    logic [knot_pkg::RC_W-1:0]     rc;
    logic [knot_pkg::CNT_W-1:0]    limit;
    logic [knot_pkg::CNT_W-1:0]    want;
    logic                          accept;

    // Shared round unit
    assign rc = knot_pkg::round_const(r_set, r_rnd);

    knot_round u_round (
        .i_rows (r_rows),
        .i_rc   (rc),
        .o_rows (rnd_out)
    );

    assign busy        = (r_state == ST_RUN);
    assign o_cfg_ready = !busy && !start;
    assign accept      = start && !busy;

    // Saturate the requested count
    assign limit = (r_set == knot_pkg::SET_SEQ7) ? knot_pkg::LEN_SEQ7 : knot_pkg::LEN_SEQ6;
    assign want  = (i_item.round_count > limit) ? limit : i_item.round_count;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_set   = r_set;
        n_clip  = r_clip;
        n_rnd   = r_rnd;
        n_last  = r_last;
        n_rows  = r_rows;

        // config transfer
        if (i_cfg_valid && o_cfg_ready) begin
            n_set = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rows[0] = i_item.row_0_in;
                    n_rows[1] = i_item.row_1_in;
                    n_rows[2] = i_item.row_2_in;
                    n_rows[3] = i_item.row_3_in;
                    n_clip    = (i_item.round_count > limit);
                    n_rnd     = '0;
                    n_last    = want - 7'd1;
                    if (want == '0) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                n_rows = rnd_out;
                n_rnd  = r_rnd + 7'd1;
                if (r_rnd == r_last) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_set   <= knot_pkg::SET_SEQ6;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_set   <= n_set;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_clip <= n_clip;
        r_rnd  <= n_rnd;
        r_last <= n_last;
        r_rows <= n_rows;
    end

    // Result straight from the working rows
    assign o_result_valid          = r_valid;
    assign o_result.row_0_out      = r_rows[0];
    assign o_result.row_1_out      = r_rows[1];
    assign o_result.row_2_out      = r_rows[2];
    assign o_result.row_3_out      = r_rows[3];
    assign o_result.count_clipped  = r_clip;

endmodule
